// ===== sv/pfc_pkg.sv =====
package pfc_pkg;

	localparam int CELLS   = 25;
	localparam int LETTERS = 26;
	localparam int SIDE    = 5;
	localparam int ADDR_W  = 3;

	localparam logic [2:0] RC_MAX = 3'(SIDE - 1);

	localparam logic [4:0] LETTER_I     = 5'd8;
	localparam logic [4:0] LETTER_J     = 5'd9;
	localparam logic [4:0] LETTER_Z     = 5'd25;
	localparam logic [4:0] FILLER_RESET = 5'd23;
	localparam logic [4:0] PAD_RESET    = 5'd23;
	localparam logic [4:0] FILL_FULL    = 5'(CELLS);

	localparam logic [2:0] OP_KEY_LETTER = 3'd0;
	localparam logic [2:0] OP_KEY_END    = 3'd1;
	localparam logic [2:0] OP_ENC_LETTER = 3'd2;
	localparam logic [2:0] OP_ENC_END    = 3'd3;
	localparam logic [2:0] OP_DEC_LETTER = 3'd4;
	localparam logic [2:0] OP_DEC_END    = 3'd5;

	localparam logic REG_FILLER = 1'b0;
	localparam logic REG_PAD    = 1'b1;

	typedef logic [4:0] letter_t;

	typedef struct packed {
		logic latch;
		logic place;
		logic pair;
		logic fill_init;
		logic fill_step;
		logic pos_rd;
		logic cell_rd;
		logic emit_a;
		logic emit_b;
		logic emit_mark;
	} cmd_t;

	typedef struct packed {
		logic is_key;
		logic is_key_end;
		logic is_pairing;
		logic is_word_end;
		logic dig;
		logic fill_last;
		logic slot_free;
	} sts_t;

endpackage

// ===== sv/pfc_if.sv =====
interface pfc_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [4:0] letter_in;

	modport source(output valid, opcode, letter_in, input ready);
	modport sink(input valid, opcode, letter_in, output ready);
endinterface

interface pfc_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] letter_out;
	logic       word_marker;
	logic       last;

	modport source(output valid, letter_out, word_marker, last, input ready);
	modport sink(input valid, letter_out, word_marker, last, output ready);
endinterface

// ===== sv/pfc_dpath.sv =====
module pfc_dpath import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [2:0] opcode,
	input  letter_t    letter_in,
	input  logic       res_ready,
	output logic       res_valid,
	output letter_t    letter_out,
	output logic       word_marker,
	output logic       last,
	input  logic       cfg_we,
	input  logic       cfg_sel,
	input  letter_t    cfg_data,
	output letter_t    filler_raw,
	output letter_t    pad_raw
);

	function automatic letter_t norm_letter(input letter_t v);
		letter_t x;
		x = (v > LETTER_Z) ? LETTER_Z : v;
		if (x == LETTER_J) begin
			x = LETTER_I;
		end
		return x;
	endfunction

	function automatic logic [2:0] pos_row(input letter_t p);
		logic [2:0] r;
		if (p >= 5'd20) begin
			r = 3'd4;
		end else if (p >= 5'd15) begin
			r = 3'd3;
		end else if (p >= 5'd10) begin
			r = 3'd2;
		end else if (p >= 5'd5) begin
			r = 3'd1;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic logic [2:0] pos_col(input letter_t p, input logic [2:0] r);
		letter_t c;
		c = p - {r, 2'b00} - {2'b00, r};
		return c[2:0];
	endfunction

	function automatic logic [2:0] rc_step(input logic [2:0] x, input logic dec);
		logic [2:0] y;
		if (dec) begin
			y = (x == 3'd0) ? RC_MAX : x - 3'd1;
		end else begin
			y = (x == RC_MAX) ? 3'd0 : x + 3'd1;
		end
		return y;
	endfunction

	function automatic letter_t cell_index(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

	letter_t square_mem [CELLS];
	letter_t pos_mem [LETTERS];

	logic [2:0]         op_q;
	letter_t            lit_q;
	letter_t            prev_q;
	logic               prev_vld_q;
	letter_t            pend_q;
	logic               pend_vld_q;
	letter_t            a_q;
	letter_t            b_q;
	logic               dec_q;
	logic [LETTERS-1:0] used_q;
	letter_t            fill_cnt_q;
	letter_t            k_q;
	letter_t            pa_q;
	letter_t            pb_q;
	letter_t            ca_q;
	letter_t            cb_q;
	letter_t            filler_q;
	letter_t            pad_q;
	logic               res_valid_q;
	letter_t            res_letter_q;
	logic               res_marker_q;
	logic               res_last_q;

	letter_t    filler_n;
	letter_t    pad_n;
	logic       dup;
	logic       dig;
	letter_t    na;
	letter_t    nb;
	letter_t    npend;
	logic       npend_vld;
	logic       place_req;
	letter_t    place_let;
	logic       do_place;
	logic [2:0] ra, ca, rb, cb;
	logic [2:0] ra2, ca2, rb2, cb2;
	letter_t    ia, ib;

	assign filler_n = norm_letter(filler_q);
	assign pad_n    = norm_letter(pad_q);
	assign dup      = prev_vld_q && (prev_q == lit_q) && (op_q == OP_ENC_LETTER);

	always_comb begin
		dig       = 1'b0;
		na        = pend_q;
		nb        = lit_q;
		npend     = pend_q;
		npend_vld = pend_vld_q;
		case (op_q)
			OP_ENC_LETTER: begin
				if (dup) begin
					dig = 1'b1;
					if (pend_vld_q) begin
						nb        = filler_n;
						npend     = lit_q;
						npend_vld = 1'b1;
					end else begin
						na        = filler_n;
						npend_vld = 1'b0;
					end
				end else if (pend_vld_q) begin
					dig       = 1'b1;
					npend_vld = 1'b0;
				end else begin
					npend     = lit_q;
					npend_vld = 1'b1;
				end
			end
			OP_DEC_LETTER: begin
				if (pend_vld_q) begin
					dig       = 1'b1;
					npend_vld = 1'b0;
				end else begin
					npend     = lit_q;
					npend_vld = 1'b1;
				end
			end
			OP_ENC_END: begin
				dig       = pend_vld_q;
				nb        = pad_n;
				npend_vld = 1'b0;
			end
			OP_DEC_END: begin
				npend_vld = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign place_req = cmd.place || (cmd.fill_step && (k_q != LETTER_J));
	assign place_let = cmd.fill_step ? k_q : lit_q;
	assign do_place  = place_req && (fill_cnt_q < FILL_FULL) && !used_q[place_let];

	// digraph rule on registered positions
	always_comb begin
		ra  = pos_row(pa_q);
		rb  = pos_row(pb_q);
		ca  = pos_col(pa_q, ra);
		cb  = pos_col(pb_q, rb);
		ra2 = ra;
		rb2 = rb;
		ca2 = cb;
		cb2 = ca;
		if (ra == rb) begin
			ca2 = rc_step(ca, dec_q);
			cb2 = rc_step(cb, dec_q);
		end else if (ca == cb) begin
			ra2 = rc_step(ra, dec_q);
			rb2 = rc_step(rb, dec_q);
			ca2 = ca;
			cb2 = cb;
		end
		ia = cell_index(ra2, ca2);
		ib = cell_index(rb2, cb2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_KEY_END;
			prev_vld_q  <= 1'b0;
			pend_vld_q  <= 1'b0;
			used_q      <= '0;
			fill_cnt_q  <= '0;
			k_q         <= '0;
			filler_q    <= FILLER_RESET;
			pad_q       <= PAD_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				op_q <= opcode;
			end
			if (cmd.pair) begin
				pend_vld_q <= npend_vld;
				prev_vld_q <= (op_q == OP_ENC_LETTER);
			end
			if (cmd.fill_init) begin
				pend_vld_q <= 1'b0;
				prev_vld_q <= 1'b0;
				k_q        <= '0;
			end
			if (cmd.fill_step) begin
				k_q <= k_q + 5'd1;
			end
			if (do_place) begin
				used_q[place_let] <= 1'b1;
				fill_cnt_q        <= fill_cnt_q + 5'd1;
			end
			if (cfg_we) begin
				if (cfg_sel == REG_FILLER) begin
					filler_q <= cfg_data;
				end else begin
					pad_q <= cfg_data;
				end
			end
			if (cmd.emit_a || cmd.emit_b || cmd.emit_mark) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			lit_q <= norm_letter(letter_in);
		end
		if (cmd.pair) begin
			pend_q <= npend;
			prev_q <= lit_q;
			a_q    <= na;
			b_q    <= nb;
			dec_q  <= (op_q == OP_DEC_LETTER);
		end
		if (do_place) begin
			square_mem[fill_cnt_q] <= place_let;
			pos_mem[place_let]     <= fill_cnt_q;
		end
		if (cmd.pos_rd) begin
			pa_q <= pos_mem[a_q];
			pb_q <= pos_mem[b_q];
		end
		if (cmd.cell_rd) begin
			ca_q <= square_mem[ia];
			cb_q <= square_mem[ib];
		end
		if (cmd.emit_a) begin
			res_letter_q <= ca_q;
			res_marker_q <= 1'b0;
			res_last_q   <= 1'b0;
		end else if (cmd.emit_b) begin
			res_letter_q <= cb_q;
			res_marker_q <= 1'b0;
			res_last_q   <= !sts.is_word_end;
		end else if (cmd.emit_mark) begin
			res_letter_q <= '0;
			res_marker_q <= 1'b1;
			res_last_q   <= 1'b1;
		end
	end

	always_comb begin
		sts.is_key      = (op_q == OP_KEY_LETTER);
		sts.is_key_end  = (op_q == OP_KEY_END);
		sts.is_pairing  = op_q inside {OP_ENC_LETTER, OP_ENC_END, OP_DEC_LETTER, OP_DEC_END};
		sts.is_word_end = (op_q == OP_ENC_END) || (op_q == OP_DEC_END);
		sts.dig         = dig;
		sts.fill_last   = (k_q == LETTER_Z);
		sts.slot_free   = !res_valid_q || res_ready;
	end

	assign res_valid   = res_valid_q;
	assign letter_out  = res_letter_q;
	assign word_marker = res_marker_q;
	assign last        = res_last_q;
	assign filler_raw  = filler_q;
	assign pad_raw     = pad_q;

endmodule

// ===== sv/pfc_ctrl.sv =====
module pfc_ctrl import pfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DISP = 8'b0000_0010,
		S_FILL = 8'b0000_0100,
		S_POS  = 8'b0000_1000,
		S_CELL = 8'b0001_0000,
		S_OUTA = 8'b0010_0000,
		S_OUTB = 8'b0100_0000,
		S_MARK = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_n  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_n   = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_key) begin
					cmd.place = 1'b1;
					state_n   = S_IDLE;
				end else if (sts.is_key_end) begin
					cmd.fill_init = 1'b1;
					state_n       = S_FILL;
				end else if (sts.is_pairing) begin
					cmd.pair = 1'b1;
					if (sts.dig) begin
						state_n = S_POS;
					end else if (sts.is_word_end) begin
						state_n = S_MARK;
					end else begin
						state_n = S_IDLE;
					end
				end else begin
					state_n = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_n = S_IDLE;
				end
			end
			S_POS: begin
				cmd.pos_rd = 1'b1;
				state_n    = S_CELL;
			end
			S_CELL: begin
				cmd.cell_rd = 1'b1;
				state_n     = S_OUTA;
			end
			S_OUTA: begin
				if (sts.slot_free) begin
					cmd.emit_a = 1'b1;
					state_n    = S_OUTB;
				end
			end
			S_OUTB: begin
				if (sts.slot_free) begin
					cmd.emit_b = 1'b1;
					state_n    = sts.is_word_end ? S_MARK : S_IDLE;
				end
			end
			S_MARK: begin
				if (sts.slot_free) begin
					cmd.emit_mark = 1'b1;
					state_n       = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

`ifndef SYNTH
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DISP)
		else $error("accepted transaction not dispatched");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_a || cmd.emit_b || cmd.emit_mark |-> sts.slot_free)
		else $error("result loaded over a pending transaction");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	a_pos_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POS |-> $past(state_q) == S_DISP)
		else $error("digraph lookup without pairing");

	a_mark_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> ($past(state_q) == S_DISP || $past(state_q) == S_OUTB
			|| $past(state_q) == S_MARK))
		else $error("marker reached from wrong state");
`endif

endmodule

// ===== sv/playfair_digraph_cipher.sv =====
// A digraph's results pass through dispatch, position read, cell read and two output
// loads, a word-end marker load after them; each load waits for a free output register.
// One transaction is taken at a time. A key letter or an item with no result needs only
// dispatch, a lone marker adds its load, and a key end fills the square over every code.
// The output register lets the next transaction start while the final result waits.
// Asynchronous active-low reset empties the square and clears pairing state.
module playfair_digraph_cipher import pfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pfc_item_if.sink          items,
	pfc_result_if.source      results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cmd_t    cmd;
	sts_t    sts;
	logic    cfg_we;
	logic    cfg_sel;
	letter_t filler_raw;
	letter_t pad_raw;

	assign cfg_we  = psel && penable && pwrite;
	assign cfg_sel = paddr[ADDR_W-1];
	assign pready  = 1'b1;
	assign prdata  = {27'd0, (cfg_sel == REG_PAD) ? pad_raw : filler_raw};

	pfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (items.opcode),
		.letter_in   (items.letter_in),
		.res_ready   (results.ready),
		.res_valid   (results.valid),
		.letter_out  (results.letter_out),
		.word_marker (results.word_marker),
		.last        (results.last),
		.cfg_we      (cfg_we),
		.cfg_sel     (cfg_sel),
		.cfg_data    (pwdata[4:0]),
		.filler_raw  (filler_raw),
		.pad_raw     (pad_raw)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import pfc_pkg::*;

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 110;

	typedef struct {
		letter_t letter;
		logic    marker;
		logic    last;
	} cipher_out_t;

	class digraph_scoreboard;
		letter_t            square[CELLS];
		logic [4:0]         cell_of[LETTERS];
		logic [LETTERS-1:0] used;
		int                 fill;
		bit                 prev_ok;
		letter_t            prev_letter;
		bit                 pend_ok;
		letter_t            pend_letter;
		logic [4:0]         filler_reg;
		logic [4:0]         pad_reg;
		cipher_out_t        expected_q[$];
		cipher_out_t        batch[$];
		int                 mismatches;
		int                 checked;

		function new();
			used       = '0;
			fill       = 0;
			prev_ok    = 0;
			pend_ok    = 0;
			filler_reg = FILLER_RESET;
			pad_reg    = PAD_RESET;
			mismatches = 0;
			checked    = 0;
		endfunction

		// out-of-range codes saturate to z, j folds onto i
		function letter_t fold(logic [4:0] v);
			letter_t x;
			x = v;
			if (x > LETTER_Z) x = LETTER_Z;
			if (x == LETTER_J) x = LETTER_I;
			return x;
		endfunction

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == REG_FILLER) filler_reg = value[4:0];
			else pad_reg = value[4:0];
		endfunction

		function void place(letter_t l);
			if (fill >= CELLS || used[l]) return;
			square[fill] = l;
			cell_of[l]   = 5'(fill);
			used[l]      = 1'b1;
			fill++;
		endfunction

		function void emit(letter_t l, logic marker);
			cipher_out_t r;
			r.letter = l;
			r.marker = marker;
			r.last   = 1'b0;
			batch    = {batch, r};
		endfunction

		function void encipher(letter_t a, letter_t b, bit decrypt);
			int ra, ca, rb, cb, step, t;
			ra   = cell_of[a] / SIDE;
			ca   = cell_of[a] % SIDE;
			rb   = cell_of[b] / SIDE;
			cb   = cell_of[b] % SIDE;
			step = decrypt ? SIDE - 1 : 1;
			if (ra == rb) begin
				ca = (ca + step) % SIDE;
				cb = (cb + step) % SIDE;
			end else if (ca == cb) begin
				ra = (ra + step) % SIDE;
				rb = (rb + step) % SIDE;
			end else begin
				t  = ca;
				ca = cb;
				cb = t;
			end
			emit(square[ra * SIDE + ca], 1'b0);
			emit(square[rb * SIDE + cb], 1'b0);
		endfunction

		function void pair_up(letter_t l, bit decrypt);
			if (!pend_ok) begin
				pend_letter = l;
				pend_ok     = 1'b1;
			end else begin
				encipher(pend_letter, l, decrypt);
				pend_ok = 1'b0;
			end
		endfunction

		function void note_item(logic [2:0] op, logic [4:0] raw);
			letter_t     l;
			cipher_out_t r;
			l = fold(raw);
			batch.delete();
			case (op)
				OP_KEY_LETTER: place(l);
				OP_KEY_END: begin
					for (int k = 0; k < LETTERS; k++)
						if (5'(k) != LETTER_J) place(5'(k));
					prev_ok = 1'b0;
					pend_ok = 1'b0;
				end
				OP_ENC_LETTER: begin
					if (prev_ok && prev_letter == l) pair_up(fold(filler_reg), 1'b0);
					pair_up(l, 1'b0);
					prev_letter = l;
					prev_ok     = 1'b1;
				end
				OP_ENC_END, OP_DEC_END: begin
					if (pend_ok && op == OP_ENC_END)
						encipher(pend_letter, fold(pad_reg), 1'b0);
					pend_ok = 1'b0;
					prev_ok = 1'b0;
					emit('0, 1'b1);
				end
				OP_DEC_LETTER: begin
					pair_up(l, 1'b1);
					prev_ok = 1'b0;
				end
				default: ;
			endcase
			foreach (batch[i]) begin
				r          = batch[i];
				r.last     = (i == batch.size() - 1);
				expected_q = {expected_q, r};
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH at result %0d: %s", checked, msg);
		endtask

		task check_result(letter_t l, logic m, logic lst);
			cipher_out_t e;
			checked++;
			if (expected_q.size() == 0) begin
				report($sformatf("nothing expected, got letter %0d marker %0b last %0b",
					l, m, lst));
				return;
			end
			e = expected_q.pop_front();
			if (l !== e.letter) report($sformatf("letter_out %0d, want %0d", l, e.letter));
			if (m !== e.marker) report($sformatf("word_marker %0b, want %0b", m, e.marker));
			if (lst !== e.last) report($sformatf("last %0b, want %0b", lst, e.last));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	bit                steady;
	int                quiet;
	int                op_count[8];
	int                work_items;
	digraph_scoreboard sb;

	pfc_item_if   items_ch();
	pfc_result_if results_ch();

	playfair_digraph_cipher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet == WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] op, logic [4:0] letter);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid     <= 1'b1;
		items_ch.opcode    <= op;
		items_ch.letter_in <= letter;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
		sb.note_item(op, letter);
		op_count[op]++;
		if (op inside {OP_ENC_LETTER, OP_ENC_END, OP_DEC_LETTER, OP_DEC_END}) work_items++;
	endtask

	function automatic logic [4:0] pick_letter();
		return ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 25));
	endfunction

	// well-formed word; roughly a quarter of letters repeat the previous code
	task automatic send_word(bit decrypt);
		int         len;
		logic [4:0] letter;
		len    = $urandom_range(0, 7);
		letter = pick_letter();
		for (int i = 0; i < len; i++) begin
			if (i == 0 || $urandom_range(0, 3) != 0) letter = pick_letter();
			send_item(decrypt ? OP_DEC_LETTER : OP_ENC_LETTER, letter);
		end
		send_item(decrypt ? OP_DEC_END : OP_ENC_END, 5'($urandom_range(0, 31)));
	endtask

	task automatic drain();
		items_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		int stall;
		results_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
			while (!results_ch.valid) @(posedge clk);
			sb.check_result(results_ch.letter_out, results_ch.word_marker, results_ch.last);
		end
	end

	initial begin
		logic [7:0]  opening[29];
		logic [31:0] filler_vals[4];
		logic [31:0] pad_vals[4];
		int          r;

		opening = '{
			{OP_ENC_END, 5'd0}, {OP_DEC_END, 5'd31}, {OP_SPARE_6, 5'd12}, {OP_SPARE_7, 5'd31},
			{OP_KEY_LETTER, 5'd15}, {OP_KEY_LETTER, 5'd11}, {OP_KEY_LETTER, 5'd0},
			{OP_KEY_LETTER, 5'd24}, {OP_KEY_LETTER, 5'd5}, {OP_KEY_LETTER, 5'd9},
			{OP_KEY_LETTER, 5'd17}, {OP_KEY_LETTER, 5'd4}, {OP_KEY_LETTER, 5'd31},
			{OP_KEY_LETTER, 5'd0}, {OP_KEY_LETTER, 5'd8},
			{OP_KEY_END, 5'd0}, {OP_KEY_END, 5'd31}, {OP_KEY_LETTER, 5'd2},
			{OP_ENC_LETTER, 5'd7}, {OP_ENC_LETTER, 5'd4}, {OP_ENC_LETTER, 5'd4},
			{OP_ENC_LETTER, 5'd23}, {OP_ENC_LETTER, 5'd23}, {OP_ENC_LETTER, 5'd31},
			{OP_ENC_END, 5'd0},
			{OP_DEC_LETTER, 5'd0}, {OP_DEC_LETTER, 5'd31}, {OP_DEC_LETTER, 5'd9},
			{OP_DEC_END, 5'd0}
		};
		filler_vals = '{32'd0, 32'd25, 32'd31, $urandom()};
		pad_vals    = '{32'd31, 32'd9, 32'd0, $urandom()};

		clk                = 1'b0;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		items_ch.valid     = 1'b0;
		items_ch.opcode    = OP_KEY_LETTER;
		items_ch.letter_in = '0;
		steady             = 1'b0;
		quiet              = 0;
		work_items         = 0;
		sb                 = new();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_item(opening[i][7:5], opening[i][4:0]);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_FILLER, filler_vals[p]);
			write_reg(REG_PAD, pad_vals[p]);
			steady     = (p == 1);
			work_items = 0;
			while (work_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 9);
				if (r == 0) send_item(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
				else send_word(r <= 3);
			end
			drain();
			steady = 1'b0;
		end

		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
		$display("Covered %0d key, %0d key-end, %0d encrypt, %0d decrypt, %0d word-end,",
			op_count[OP_KEY_LETTER], op_count[OP_KEY_END], op_count[OP_ENC_LETTER],
			op_count[OP_DEC_LETTER], op_count[OP_ENC_END] + op_count[OP_DEC_END]);
		$display("%0d spare-op transactions; %0d results checked over four register settings",
			op_count[OP_SPARE_6] + op_count[OP_SPARE_7], sb.checked);
		if (sb.mismatches == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
